// ===== rtl/cst_pkg.sv =====
package cst_pkg;

    // Field widths
    localparam int CmdW    = 3;
    localparam int SlotW   = 4;
    localparam int CountW  = 16;
    localparam int PidW    = 8;
    localparam int StatusW = 3;

    // Most woken results that one flush request may produce
    localparam int MaxResults = 16;

    localparam logic [CountW-1:0] CountMax = '1;

    // Command codes
    localparam logic [CmdW-1:0] CMD_CREATE = 3'd0;
    localparam logic [CmdW-1:0] CMD_DELETE = 3'd1;
    localparam logic [CmdW-1:0] CMD_WAIT   = 3'd2;
    localparam logic [CmdW-1:0] CMD_SIGNAL = 3'd3;
    localparam logic [CmdW-1:0] CMD_FLUSH  = 3'd4;

    // Status codes
    localparam logic [StatusW-1:0] ST_OK      = 3'd0;
    localparam logic [StatusW-1:0] ST_BLOCKED = 3'd1;
    localparam logic [StatusW-1:0] ST_WOKEN   = 3'd2;
    localparam logic [StatusW-1:0] ST_NOSLOT  = 3'd3;
    localparam logic [StatusW-1:0] ST_BADID   = 3'd4;
    localparam logic [StatusW-1:0] ST_QFULL   = 3'd5;
    localparam logic [StatusW-1:0] ST_SAT     = 3'd6;

endpackage

// ===== rtl/counting_semaphore_table.sv =====
// Counting semaphore table: NUM_SEMS semaphores, each a 16-bit count plus a FIFO of up
// to QUEUE_DEPTH waiting pids. A request (cmd, sem_id, init_value, pid) is taken on
// req_valid && req_ready; results leave on rsp_valid && rsp_ready, with last set on the
// final result of each request. Create, delete, wait and signal without a waiter pass
// through accept + slot-memory read, then decide + write back; a signal that wakes a
// waiter also reads the waiter memory after the slot entry. Flush emits one result per
// woken pid (at most 16 per request; the rest stay queued). Output back-pressure adds
// stall cycles. The per-slot count, queue head and fill live in one synchronous memory,
// the pids in a second one (NUM_SEMS*QUEUE_DEPTH entries); only the slot-in-use bits
// are flops, cleared at reset, so no clearing pass is needed. Unused entries are
// rewritten by create before any read can reach them.
module counting_semaphore_table
    import cst_pkg::*;
#(
    parameter int NUM_SEMS    = 16,
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               req_valid,
    output logic               req_ready,
    input  logic [CmdW-1:0]    cmd,
    input  logic [SlotW-1:0]   sem_id,
    input  logic [CountW-1:0]  init_value,
    input  logic [PidW-1:0]    pid,

    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [StatusW-1:0] status,
    output logic [SlotW-1:0]   slot,
    output logic [CountW-1:0]  count,
    output logic [PidW-1:0]    woken_pid,
    output logic               last
);

    localparam int IdxW  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int HeadW = $clog2(QUEUE_DEPTH);
    localparam int FillW = $clog2(QUEUE_DEPTH + 1);
    localparam int WAddrW = $clog2(NUM_SEMS * QUEUE_DEPTH);
    localparam int EntW  = CountW + HeadW + FillW;
    localparam int NW    = $clog2(MaxResults);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [1:0]          state_reg, state_next;
    logic [NUM_SEMS-1:0] in_use_reg, in_use_next;

    logic [CmdW-1:0]     cmd_reg;
    logic [SlotW-1:0]    sem_id_reg;
    logic [CountW-1:0]   init_reg;
    logic [PidW-1:0]     pid_reg;

    // Pop/flush working registers
    logic [CountW-1:0]   pop_count_reg, pop_count_next;
    logic [HeadW-1:0]    pop_head_reg, pop_head_next;
    logic [FillW-1:0]    pop_fill_reg, pop_fill_next;
    logic [NW-1:0]       pop_n_reg, pop_n_next;
    logic                pop_flush_reg, pop_flush_next;

    // Output register
    logic                rsp_valid_reg, rsp_valid_next;
    logic [StatusW-1:0]  status_reg, status_next;
    logic [SlotW-1:0]    slot_reg, slot_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic [PidW-1:0]     woken_reg, woken_next;
    logic                last_reg, last_next;

    // Slot memory: {count, head, fill}
    logic [EntW-1:0]     sem_mem [NUM_SEMS];
    logic [EntW-1:0]     sem_rdata_reg;
    logic                sem_re, sem_we;
    logic [IdxW-1:0]     sem_raddr, sem_waddr;
    logic [EntW-1:0]     sem_wdata;

    // Waiter memory
    logic [PidW-1:0]     wt_mem [NUM_SEMS * QUEUE_DEPTH];
    logic [PidW-1:0]     wt_rdata_reg;
    logic                wt_re, wt_we;
    logic [WAddrW-1:0]   wt_raddr, wt_waddr;

    // ---------------------------------------------------------------
    // Decode of the slot entry just read
    // ---------------------------------------------------------------
    logic [CountW-1:0]   cur_count;
    logic [HeadW-1:0]    cur_head;
    logic [FillW-1:0]    cur_fill;
    logic [IdxW-1:0]     idx;
    logic                sem_ok, bad_id, emit_ok;
    logic [HeadW:0]      tail_sum;
    logic [HeadW-1:0]    tail_pos;

    logic [NUM_SEMS-1:0] free_vec, free_low;
    logic                any_free;
    logic [IdxW-1:0]     free_idx;

    function automatic logic [WAddrW-1:0] wt_addr(input logic [IdxW-1:0] s,
                                                  input logic [HeadW-1:0] pos);
        wt_addr = WAddrW'(s) * WAddrW'(QUEUE_DEPTH) + WAddrW'(pos);
    endfunction

    function automatic logic [HeadW-1:0] head_inc(input logic [HeadW-1:0] h);
        head_inc = (h == HeadW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    assign cur_count = sem_rdata_reg[EntW-1 -: CountW];
    assign cur_head  = sem_rdata_reg[FillW +: HeadW];
    assign cur_fill  = sem_rdata_reg[FillW-1:0];

    assign idx    = IdxW'(sem_id_reg);
    assign sem_ok = 9'(sem_id_reg) < 9'(NUM_SEMS);
    assign bad_id = (cmd_reg > CMD_FLUSH) || !(sem_ok && in_use_reg[idx]);

    // Tail position for an enqueue (head + fill, wrapped once)
    assign tail_sum = (HeadW+1)'(cur_head) + (HeadW+1)'(cur_fill);
    assign tail_pos = (tail_sum >= (HeadW+1)'(QUEUE_DEPTH))
                      ? HeadW'(tail_sum - (HeadW+1)'(QUEUE_DEPTH))
                      : HeadW'(tail_sum);

    // Lowest free slot: isolate lowest set bit, then OR-encode it
    assign free_vec = ~in_use_reg;
    assign free_low = free_vec & (~free_vec + NUM_SEMS'(1));
    assign any_free = |free_vec;

    always_comb
    begin
        free_idx = '0;
        for (int i = 0; i < NUM_SEMS; i++)
        begin
            if (free_low[i])
            begin
                free_idx = free_idx | IdxW'(i);
            end
        end
    end

    assign emit_ok = !rsp_valid_reg || rsp_ready;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        in_use_next    = in_use_reg;
        req_ready      = 1'b0;
        pop_count_next = pop_count_reg;
        pop_head_next  = pop_head_reg;
        pop_fill_next  = pop_fill_reg;
        pop_n_next     = pop_n_reg;
        pop_flush_next = pop_flush_reg;

        sem_re    = 1'b0;
        sem_raddr = IdxW'(sem_id);
        sem_we    = 1'b0;
        sem_waddr = idx;
        sem_wdata = {cur_count, cur_head, cur_fill};
        wt_re     = 1'b0;
        wt_raddr  = wt_addr(idx, pop_head_reg);
        wt_we     = 1'b0;
        wt_waddr  = wt_addr(idx, tail_pos);

        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        woken_next     = woken_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    sem_re     = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (emit_ok)
                begin
                    // Most arms emit a single ok-type result
                    rsp_valid_next = 1'b1;
                    status_next    = ST_OK;
                    slot_next      = sem_id_reg;
                    count_next     = '0;
                    woken_next     = '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;

                    priority if (cmd_reg == CMD_CREATE)
                    begin
                        if (any_free)
                        begin
                            in_use_next[free_idx] = 1'b1;
                            sem_we     = 1'b1;
                            sem_waddr  = free_idx;
                            sem_wdata  = {init_reg, {HeadW{1'b0}}, {FillW{1'b0}}};
                            slot_next  = SlotW'(free_idx);
                            count_next = init_reg;
                        end
                        else
                        begin
                            status_next = ST_NOSLOT;
                            slot_next   = '0;
                        end
                    end
                    else if (bad_id)
                    begin
                        status_next = ST_BADID;
                    end
                    else if (cmd_reg == CMD_DELETE)
                    begin
                        in_use_next[idx] = 1'b0;
                    end
                    else if (cmd_reg == CMD_WAIT)
                    begin
                        if (cur_count != '0)
                        begin
                            sem_we     = 1'b1;
                            sem_wdata  = {cur_count - 1'b1, cur_head, cur_fill};
                            count_next = cur_count - 1'b1;
                        end
                        else if (cur_fill >= FillW'(QUEUE_DEPTH))
                        begin
                            status_next = ST_QFULL;
                            count_next  = cur_count;
                        end
                        else
                        begin
                            wt_we       = 1'b1;
                            sem_we      = 1'b1;
                            sem_wdata   = {cur_count, cur_head, cur_fill + 1'b1};
                            status_next = ST_BLOCKED;
                            count_next  = cur_count;
                        end
                    end
                    else if (cur_fill != '0)
                    begin
                        // Signal with a waiter, or non-empty flush: fetch queue head
                        rsp_valid_next = rsp_valid_reg && !rsp_ready;
                        status_next    = status_reg;
                        slot_next      = slot_reg;
                        count_next     = count_reg;
                        woken_next     = woken_reg;
                        last_next      = last_reg;
                        wt_re          = 1'b1;
                        wt_raddr       = wt_addr(idx, cur_head);
                        pop_head_next  = head_inc(cur_head);
                        pop_fill_next  = cur_fill - 1'b1;
                        pop_n_next     = '0;
                        pop_flush_next = (cmd_reg == CMD_FLUSH);
                        pop_count_next = (cmd_reg == CMD_FLUSH) ? '0 : cur_count;
                        state_next     = S_POP;
                    end
                    else if (cmd_reg == CMD_FLUSH)
                    begin
                        sem_we    = 1'b1;
                        sem_wdata = {{CountW{1'b0}}, cur_head, cur_fill};
                    end
                    else if (cur_count == CountMax)
                    begin
                        status_next = ST_SAT;
                        count_next  = cur_count;
                    end
                    else
                    begin
                        sem_we     = 1'b1;
                        sem_wdata  = {cur_count + 1'b1, cur_head, cur_fill};
                        count_next = cur_count + 1'b1;
                    end
                end
            end

            S_POP:
            begin
                if (emit_ok)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = ST_WOKEN;
                    slot_next      = sem_id_reg;
                    count_next     = pop_count_reg;
                    woken_next     = wt_rdata_reg;
                    last_next      = !pop_flush_reg || (pop_fill_reg == '0)
                                     || (pop_n_reg == NW'(MaxResults - 1));
                    if (last_next)
                    begin
                        sem_we     = 1'b1;
                        sem_wdata  = {pop_count_reg, pop_head_reg, pop_fill_reg};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        wt_re         = 1'b1;
                        pop_head_next = head_inc(pop_head_reg);
                        pop_fill_next = pop_fill_reg - 1'b1;
                        pop_n_next    = pop_n_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg    <= cmd;
            sem_id_reg <= sem_id;
            init_reg   <= init_value;
            pid_reg    <= pid;
        end
        pop_count_reg <= pop_count_next;
        pop_head_reg  <= pop_head_next;
        pop_fill_reg  <= pop_fill_next;
        pop_n_reg     <= pop_n_next;
        pop_flush_reg <= pop_flush_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        count_reg     <= count_next;
        woken_reg     <= woken_next;
        last_reg      <= last_next;
    end

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (sem_we)
        begin
            sem_mem[sem_waddr] <= sem_wdata;
        end
        if (sem_re)
        begin
            sem_rdata_reg <= sem_mem[sem_raddr];
        end
    end

    // Waiter memory
    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            wt_mem[wt_waddr] <= pid_reg;
        end
        if (wt_re)
        begin
            wt_rdata_reg <= wt_mem[wt_raddr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign count     = count_reg;
    assign woken_pid = woken_reg;
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    // An accepted request keeps the sequencer busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while sequencer busy");

    // A pid is reported only with a woken status
    a_pid_only_woken: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != ST_WOKEN) |-> (woken_pid == '0))
        else $error("woken pid on non-woken result");

    // A bad-id result never carries a count
    a_badid_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_BADID) |-> (count == '0))
        else $error("bad id result with nonzero count");

    // A last result from the pop loop ends the request
    a_pop_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP && emit_ok && last_next) |=> (state_reg == S_IDLE))
        else $error("pop loop did not finish after last result");

    // A flush result always reports a cleared count
    a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP && pop_flush_reg) |-> (pop_count_reg == '0))
        else $error("flush with nonzero count");
`endif

endmodule
